// File: sv/lal_pkg.sv
// Shared types, constants and table functions for the log-average luminance block.
package lal_pkg;

  localparam int unsigned LUM_R = 13933;
  localparam int unsigned LUM_G = 46871;
  localparam int unsigned LUM_B = 4732;
  localparam int unsigned LUM_ROUND = 32768;
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned EXP_DEPTH = 4096;

  typedef struct packed {
    logic signed [15:0] lg;
    logic               last;
  } lal_entry_t;

  // fraction bits of log2(m / 2^30), m in [2^30, 2^31), by repeated squaring
  function automatic logic [63:0] log2_frac(input logic [63:0] m_in, input int nbits);
    logic [63:0] m;
    logic [63:0] r;
    m = m_in;
    r = '0;
    for (int k = 0; k < nbits; k++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  // smallest Q16 w in [1.0, 2.0) with log2(w) >= f/4096
  function automatic logic [16:0] exp2_entry(input logic [11:0] f);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] target;
    lo = 64'd65536;
    hi = 64'd131071;
    target = 64'(f) << 8;
    for (int k = 0; k < 18; k++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (log2_frac(mid << 14, 20) >= target) begin
          hi = mid;
        end else begin
          lo = mid + 64'd1;
        end
      end
    end
    return lo[16:0];
  endfunction

endpackage

// File: sv/log_average_luminance.sv
// Top level of the log-average (geometric mean) luminance block.
// Each item is one HDR pixel (U8.8 red, green, blue) with a last-of-frame mark.
// The front end takes one pixel per clock while pixel_stall is low: a luminance
// multiply stage, then log2 in S4.12 from a leading-one detect and a
// LOG_TABLE_DEPTH mantissa table, written into a four-item queue. The back end
// adds one log per clock to the frame sum while it is accumulating and the
// queue is not empty. On the last pixel it runs a one-bit-per-cycle restoring
// divider of COUNT_BITS+18 steps for the rounded mean, then the exp2 fraction
// ROM lookup, then the load of the output register. Until it returns to
// accumulating, the four-item queue and the front stage register absorb five
// further pixels before pixel_stall rises. A result waiting in the output
// register does not block accumulation of the next frame.
module log_average_luminance #(
  parameter int COUNT_BITS = 22,
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [15:0] red,
  input  logic [15:0] green,
  input  logic [15:0] blue,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] average_luminance
);
  import lal_pkg::*;

  logic       push;
  lal_entry_t push_data;
  logic       full;
  logic       pop;
  logic       empty;
  lal_entry_t pop_data;

  // pixel -> log2 luminance
  lal_front #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_front (
    .clk, .rst, .red, .green, .blue, .last, .pixel_valid, .pixel_stall,
    .push, .push_data, .full
  );

  // decouples the per-pixel path from the end-of-frame divide
  lal_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .empty, .pop_data
  );

  // sum, mean, exp2, output register
  lal_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst, .empty, .pop_data, .pop, .result_valid, .result_stall,
    .average_luminance
  );

endmodule

// File: sv/lal_front.sv
// Front end: luminance and per-pixel log2 in S4.12, pushed to the queue.
module lal_front #(
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       red,
  input  logic [15:0]       green,
  input  logic [15:0]       blue,
  input  logic              last,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  output logic              push,
  output lal_pkg::lal_entry_t push_data,
  input  logic              full
);
  import lal_pkg::*;

  localparam int IDXW = (LOG_TABLE_DEPTH > 1) ? $clog2(LOG_TABLE_DEPTH) : 1;
  localparam int DW = $clog2(LOG_TABLE_DEPTH + 1);

  logic [15:0] mant_rom [LOG_TABLE_DEPTH];

  for (genvar i = 0; i < LOG_TABLE_DEPTH; i++) begin : g_mant
    localparam logic [63:0] M =
      ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / 64'(LOG_TABLE_DEPTH);
    localparam logic [63:0] L = log2_frac(M, 13) + 64'd1;
    assign mant_rom[i] = L[16:1];
  end

  logic        s1_valid;
  logic [15:0] lum;
  logic        s1_last;
  logic        advance;
  logic [32:0] lum_sum;

  assign pixel_stall = s1_valid && full;
  assign advance = !pixel_stall;
  assign lum_sum = 33'(LUM_R * 32'(red)) + 33'(LUM_G * 32'(green))
                 + 33'(LUM_B * 32'(blue)) + 33'(LUM_ROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pixel_valid;
    end
    if (advance && pixel_valid) begin
      lum <= lum_sum[31:16];
      s1_last <= last;
    end
  end

  logic [16:0]        v;
  logic [4:0]         p;
  logic [16:0]        vn;
  logic [15:0]        m16;
  logic [16+DW-1:0]   prod;
  logic [IDXW-1:0]    idx;
  logic signed [18:0] lg_full;

  always_comb begin
    v = 17'(lum) + 17'd1;
    p = '0;
    for (int k = 0; k < 17; k++) begin
      if (v[k]) begin
        p = 5'(k);
      end
    end
    vn = v << (5'd16 - p);
    m16 = vn[15:0];
    prod = (16 + DW)'(m16) * (16 + DW)'(LOG_TABLE_DEPTH);
    idx = IDXW'(prod >> 16);
    lg_full = 19'(($signed({14'd0, p}) - 19'sd8) * 19'sd4096)
            + $signed({3'd0, mant_rom[idx]});
    push_data.lg = (lg_full > 19'sd32767) ? 16'sd32767 : lg_full[15:0];
    push_data.last = s1_last;
  end

  assign push = s1_valid && !full;

endmodule

// File: sv/lal_queue.sv
// Small FIFO between the front end and the accumulate/divide back end.
module lal_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lal_pkg::lal_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output lal_pkg::lal_entry_t pop_data
);
  import lal_pkg::*;

  localparam int DEPTH = 4;

  lal_entry_t mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign full = (fill == 3'(DEPTH));
  assign empty = (fill == 3'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
    if (push) mem[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> !empty)
    else $error("fill count lost a push");

endmodule

// File: sv/lal_back.sv
// Back end: log accumulation, serial mean division, exp2 lookup and output register.
module lal_back #(
  parameter int COUNT_BITS = 22
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  lal_pkg::lal_entry_t pop_data,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [15:0]         average_luminance
);
  import lal_pkg::*;

  localparam int SW = COUNT_BITS + 17;
  localparam int NW = COUNT_BITS + 18;
  localparam int RW = COUNT_BITS + 3;
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [3:0] {
    ST_ACC = 4'b0001,
    ST_DIV = 4'b0010,
    ST_FIX = 4'b0100,
    ST_OUT = 4'b1000
  } state_t;

  logic [16:0] exp_rom [EXP_DEPTH];
  for (genvar i = 0; i < EXP_DEPTH; i++) begin : g_exp
    localparam logic [16:0] W = exp2_entry(12'(i));
    assign exp_rom[i] = W;
  end

  state_t                state;
  logic signed [SW-1:0]  log_sum;
  logic [COUNT_BITS:0]   pixel_count;
  logic [NW-1:0]         dvd;
  logic [RW-1:0]         dvs;
  logic [RW-1:0]         rem;
  logic                  neg;
  logic [CW-1:0]         steps;
  logic [16:0]           exp_w;
  logic [3:0]            exp_e;

  logic                  take;
  logic signed [SW-1:0]  sum_upd;
  logic [COUNT_BITS:0]   cnt_upd;
  logic signed [NW:0]    n_val;
  logic [RW-1:0]         trial;
  logic signed [NW+1:0]  q_full;
  logic [15:0]           q16;
  logic [15:0]           t_val;
  logic [31:0]           shifted;
  logic [32:0]           res_full;
  logic                  out_free;

  assign pop = (state == ST_ACC) && !empty;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    take = pixel_count < (COUNT_BITS + 1)'(1 << COUNT_BITS);
    sum_upd = take ? log_sum + SW'(pop_data.lg) : log_sum;
    cnt_upd = take ? pixel_count + 1'b1 : pixel_count;
    n_val = ((NW + 1)'(sum_upd) <<< 1) + $signed((NW + 1)'(cnt_upd));
    trial = {rem[RW-2:0], dvd[NW-1]};
    q_full = neg ? -$signed({2'b0, dvd} + (NW + 2)'(rem != '0))
                 : $signed({2'b0, dvd});
    if (q_full > (NW + 2)'(32767)) begin
      q16 = 16'h7fff;
    end else if (q_full < -(NW + 2)'(32768)) begin
      q16 = 16'h8000;
    end else begin
      q16 = q_full[15:0];
    end
    t_val = q16 ^ 16'h8000;
    shifted = 32'(exp_w) << exp_e;
    res_full = 33'(shifted) + 33'd128;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      log_sum <= '0;
      pixel_count <= '0;
      result_valid <= 1'b0;
    end else begin
      // a held result stays valid; the register reloads only once it is free
      if (state == ST_OUT) begin
        if (out_free) result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_ACC: begin
          if (pop) begin
            if (pop_data.last) begin
              log_sum <= '0;
              pixel_count <= '0;
              state <= ST_DIV;
            end else begin
              log_sum <= sum_upd;
              pixel_count <= cnt_upd;
            end
          end
        end
        ST_DIV: begin
          if (steps == CW'(NW - 1)) state <= ST_FIX;
        end
        ST_FIX: state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
    case (state)
      ST_ACC: begin
        neg <= n_val[NW];
        dvd <= n_val[NW] ? NW'(-n_val) : NW'(n_val);
        dvs <= RW'({cnt_upd, 1'b0});
        rem <= '0;
        steps <= '0;
      end
      ST_DIV: begin
        steps <= steps + 1'b1;
        if (trial >= dvs) begin
          rem <= trial - dvs;
          dvd <= {dvd[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          dvd <= {dvd[NW-2:0], 1'b0};
        end
      end
      ST_FIX: begin
        exp_w <= exp_rom[t_val[11:0]];
        exp_e <= t_val[15:12];
      end
      ST_OUT: begin
        if (out_free) begin
          average_luminance <= (res_full[32:8] > 25'd65535) ? 16'hffff : res_full[23:8];
        end
      end
      default: ;
    endcase
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("back state not one-hot");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pixel_count <= (COUNT_BITS + 1)'(1 << COUNT_BITS))
    else $error("pixel count past limit");
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (pixel_count == '0 && log_sum == '0))
    else $error("frame state not cleared at division");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ACC) |-> !pop)
    else $error("item taken while dividing");

endmodule
